/* rtl/bhp_pkg.sv */
// ----------------------------------------------------------------------------
// bhp_pkg
// Phase, role and status codes and the result type of the belief packet
// header parser.
// ----------------------------------------------------------------------------
package bhp_pkg;

   localparam int PHASE_W = 4;
   localparam int ROLE_W  = 4;
   localparam int STAT_W  = 2;
   localparam int LEN_W   = 16;
   localparam int TIME_W  = 64;
   localparam int BYTE_W  = 8;

   localparam logic [PHASE_W-1:0] PH_FLAGS    = 4'd0;
   localparam logic [PHASE_W-1:0] PH_SKIP1    = 4'd1;
   localparam logic [PHASE_W-1:0] PH_OPTLEN   = 4'd2;
   localparam logic [PHASE_W-1:0] PH_OPTBODY  = 4'd3;
   localparam logic [PHASE_W-1:0] PH_SKIP8    = 4'd4;
   localparam logic [PHASE_W-1:0] PH_NAMELEN  = 4'd5;
   localparam logic [PHASE_W-1:0] PH_NAME     = 4'd6;
   localparam logic [PHASE_W-1:0] PH_TS       = 4'd7;
   localparam logic [PHASE_W-1:0] PH_TX       = 4'd8;
   localparam logic [PHASE_W-1:0] PH_AGENTLEN = 4'd9;
   localparam logic [PHASE_W-1:0] PH_AGENT    = 4'd10;
   localparam logic [PHASE_W-1:0] PH_PAYLOAD  = 4'd11;
   localparam logic [PHASE_W-1:0] PH_IGNORE   = 4'd12;

   localparam logic [ROLE_W-1:0] ROLE_FLAGS     = 4'd0;
   localparam logic [ROLE_W-1:0] ROLE_SKIPPED   = 4'd1;
   localparam logic [ROLE_W-1:0] ROLE_OPTION    = 4'd2;
   localparam logic [ROLE_W-1:0] ROLE_NAME_LEN  = 4'd3;
   localparam logic [ROLE_W-1:0] ROLE_NAME      = 4'd4;
   localparam logic [ROLE_W-1:0] ROLE_TIMESTAMP = 4'd5;
   localparam logic [ROLE_W-1:0] ROLE_TRANSMIT  = 4'd6;
   localparam logic [ROLE_W-1:0] ROLE_AGENT_LEN = 4'd7;
   localparam logic [ROLE_W-1:0] ROLE_AGENT     = 4'd8;
   localparam logic [ROLE_W-1:0] ROLE_PAYLOAD   = 4'd9;

   localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
   localparam logic [STAT_W-1:0] ST_COMPRESSED = 2'd1;
   localparam logic [STAT_W-1:0] ST_DROPPED    = 2'd2;
   localparam logic [STAT_W-1:0] ST_TRUNCATED  = 2'd3;

   localparam logic [BYTE_W-1:0] COMP_MASK  = 8'h1C;
   localparam logic [BYTE_W-1:0] COMP_VALUE = 8'h04;
   localparam logic [BYTE_W-1:0] OPT_LEN_MASK = 8'h7F;
   localparam int SKIP_COUNT = 8;
   localparam int TIME_BYTES = 8;
   localparam int LEN_BYTES  = 2;

   localparam logic [LEN_W-1:0] AGENT_LIMIT_RESET = 16'd256;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic [ROLE_W-1:0] role;
      logic [LEN_W-1:0]  name_length;
      logic [TIME_W-1:0] origin_time_ms;
      logic [TIME_W-1:0] transmit_time_ms;
      logic [STAT_W-1:0] status;
      logic              last;
   } result_type;

endpackage

/* rtl/bhp_parser.sv */
// ----------------------------------------------------------------------------
// bhp_parser
// Per-byte header walker: holds the packet state and forms the tagged result
// for the byte being accepted.
// ----------------------------------------------------------------------------
module bhp_parser import bhp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic              end_of_packet,
   input  logic [LEN_W-1:0]  agent_limit,
   output result_type        result
);

   logic [PHASE_W-1:0] phase_ff, phase_in, phase_nx;
   logic [LEN_W-1:0]   left_ff, left_in, left_nx, left_dec;
   logic               more_ff, more_in, more_nx;
   logic [LEN_W-1:0]   name_len_ff, name_len_in, name_len_nx;
   logic [TIME_W-1:0]  ts_ff, ts_in, ts_nx;
   logic [TIME_W-1:0]  tx_ff, tx_in, tx_nx;
   logic [STAT_W-1:0]  pstate_ff, pstate_in, pstate_nx;
   logic [LEN_W-1:0]   agent_len_ff, agent_len_in, agent_len_nx;
   logic [ROLE_W-1:0]  role;
   logic [STAT_W-1:0]  status;

   assign left_dec = left_ff - LEN_W'(1);

   always_comb begin
      phase_nx     = phase_ff;
      left_nx      = left_ff;
      more_nx      = more_ff;
      name_len_nx  = name_len_ff;
      ts_nx        = ts_ff;
      tx_nx        = tx_ff;
      pstate_nx    = pstate_ff;
      agent_len_nx = agent_len_ff;
      role         = ROLE_SKIPPED;
      case (phase_ff)
         PH_FLAGS: begin
            role = ROLE_FLAGS;
            if ((data_byte & COMP_MASK) == COMP_VALUE) begin
               pstate_nx = ST_COMPRESSED;
               phase_nx  = PH_IGNORE;
            end else begin
               more_nx  = data_byte[7];
               phase_nx = PH_SKIP1;
            end
         end
         PH_SKIP1: begin
            role = ROLE_SKIPPED;
            if (more_ff) begin
               phase_nx = PH_OPTLEN;
            end else begin
               phase_nx = PH_SKIP8;
               left_nx  = LEN_W'(SKIP_COUNT);
            end
         end
         PH_OPTLEN: begin
            role     = ROLE_OPTION;
            more_nx  = data_byte[7];
            left_nx  = LEN_W'(data_byte & OPT_LEN_MASK) + LEN_W'(1);
            phase_nx = PH_OPTBODY;
         end
         PH_OPTBODY: begin
            role    = ROLE_OPTION;
            left_nx = left_dec;
            if (left_dec == '0) begin
               if (more_ff) begin
                  phase_nx = PH_OPTLEN;
               end else begin
                  phase_nx = PH_SKIP8;
                  left_nx  = LEN_W'(SKIP_COUNT);
               end
            end
         end
         PH_SKIP8: begin
            role    = ROLE_SKIPPED;
            left_nx = left_dec;
            if (left_dec == '0) begin
               phase_nx    = PH_NAMELEN;
               left_nx     = LEN_W'(LEN_BYTES);
               name_len_nx = '0;
            end
         end
         PH_NAMELEN: begin
            role        = ROLE_NAME_LEN;
            name_len_nx = {name_len_ff[LEN_W-BYTE_W-1:0], data_byte};
            left_nx     = left_dec;
            if (left_dec == '0) begin
               if (name_len_nx == '0) begin
                  phase_nx = PH_TS;
                  left_nx  = LEN_W'(TIME_BYTES);
               end else begin
                  phase_nx = PH_NAME;
                  left_nx  = name_len_nx;
               end
            end
         end
         PH_NAME: begin
            role    = ROLE_NAME;
            left_nx = left_dec;
            if (left_dec == '0) begin
               phase_nx = PH_TS;
               left_nx  = LEN_W'(TIME_BYTES);
            end
         end
         PH_TS: begin
            role    = ROLE_TIMESTAMP;
            ts_nx   = {ts_ff[TIME_W-BYTE_W-1:0], data_byte};
            left_nx = left_dec;
            if (left_dec == '0) begin
               phase_nx = PH_TX;
               left_nx  = LEN_W'(TIME_BYTES);
            end
         end
         PH_TX: begin
            role    = ROLE_TRANSMIT;
            tx_nx   = {tx_ff[TIME_W-BYTE_W-1:0], data_byte};
            left_nx = left_dec;
            if (left_dec == '0) begin
               phase_nx     = PH_AGENTLEN;
               left_nx      = LEN_W'(LEN_BYTES);
               agent_len_nx = '0;
            end
         end
         PH_AGENTLEN: begin
            role         = ROLE_AGENT_LEN;
            agent_len_nx = {agent_len_ff[LEN_W-BYTE_W-1:0], data_byte};
            left_nx      = left_dec;
            if (left_dec == '0) begin
               if (agent_len_nx > agent_limit) begin
                  pstate_nx = ST_DROPPED;
                  phase_nx  = PH_IGNORE;
               end else if (agent_len_nx == '0) begin
                  phase_nx = PH_PAYLOAD;
               end else begin
                  phase_nx = PH_AGENT;
                  left_nx  = agent_len_nx;
               end
            end
         end
         PH_AGENT: begin
            role    = ROLE_AGENT;
            left_nx = left_dec;
            if (left_dec == '0) begin
               phase_nx = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            role = ROLE_PAYLOAD;
         end
         default: begin
            role     = ROLE_SKIPPED;
            phase_nx = PH_IGNORE;
         end
      endcase
   end

   always_comb begin
      status = pstate_nx;
      if (end_of_packet && pstate_nx == ST_OK && phase_nx != PH_PAYLOAD) begin
         status = ST_TRUNCATED;
      end
   end

   always_comb begin
      result.out_byte         = data_byte;
      result.role             = role;
      result.name_length      = (phase_nx == PH_NAMELEN) ? '0 : name_len_nx;
      result.origin_time_ms   = ts_nx;
      result.transmit_time_ms = tx_nx;
      result.status           = status;
      result.last             = end_of_packet;
   end

   always_comb begin
      phase_in     = phase_ff;
      left_in      = left_ff;
      more_in      = more_ff;
      name_len_in  = name_len_ff;
      ts_in        = ts_ff;
      tx_in        = tx_ff;
      pstate_in    = pstate_ff;
      agent_len_in = agent_len_ff;
      if (accept) begin
         if (end_of_packet) begin
            phase_in     = PH_FLAGS;
            left_in      = '0;
            more_in      = 1'b0;
            name_len_in  = '0;
            ts_in        = '0;
            tx_in        = '0;
            pstate_in    = ST_OK;
            agent_len_in = '0;
         end else begin
            phase_in     = phase_nx;
            left_in      = left_nx;
            more_in      = more_nx;
            name_len_in  = name_len_nx;
            ts_in        = ts_nx;
            tx_in        = tx_nx;
            pstate_in    = pstate_nx;
            agent_len_in = agent_len_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FLAGS;
         left_ff      <= '0;
         more_ff      <= 1'b0;
         name_len_ff  <= '0;
         ts_ff        <= '0;
         tx_ff        <= '0;
         pstate_ff    <= ST_OK;
         agent_len_ff <= '0;
      end else begin
         phase_ff     <= phase_in;
         left_ff      <= left_in;
         more_ff      <= more_in;
         name_len_ff  <= name_len_in;
         ts_ff        <= ts_in;
         tx_ff        <= tx_in;
         pstate_ff    <= pstate_in;
         agent_len_ff <= agent_len_in;
      end
   end

endmodule

/* rtl/bhp_outbuf.sv */
// ----------------------------------------------------------------------------
// bhp_outbuf
// Two-entry result buffer: output register plus skid register, so the
// upstream stall is a register output.
// ----------------------------------------------------------------------------
module bhp_outbuf import bhp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   output logic       out_valid,
   input  logic       out_stall,
   output result_type out_data
);

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       main_free;

   assign main_free = !main_valid_ff || !out_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push_data;
            main_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

/* rtl/belief_packet_header_parser.sv */
// ----------------------------------------------------------------------------
// belief_packet_header_parser
// Byte-wise belief packet header parser with role tagging and field capture.
// ----------------------------------------------------------------------------
// One packet byte is taken per cycle unless req_stall is high, and one result
// comes out per byte. The per-byte phase logic sits between the packet state
// registers and a two-entry output buffer, so the sustained rate is one item
// per clock while rsp_stall is low; req_stall rises only when both entries are
// held by a stalled result side. The user must write the agent name limit via
// the always-ready csr_ port only while the parser is idle; not enforced here.
// ----------------------------------------------------------------------------
module belief_packet_header_parser import bhp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [BYTE_W-1:0]        req_data_byte,
   input  logic                     req_end_of_packet,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [BYTE_W-1:0]        rsp_out_byte,
   output logic [ROLE_W-1:0]        rsp_role,
   output logic [LEN_W-1:0]         rsp_name_length,
   output logic signed [TIME_W-1:0] rsp_origin_time_ms,
   output logic signed [TIME_W-1:0] rsp_transmit_time_ms,
   output logic [STAT_W-1:0]        rsp_status,
   output logic                     rsp_last,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [LEN_W-1:0]         csr_data
);

   logic [LEN_W-1:0] limit_ff, limit_in;
   logic             accept;
   logic             full;
   result_type       step_result;
   result_type       rsp_data;

   assign csr_ready = 1'b1;
   assign limit_in  = (csr_valid && csr_ready) ? csr_data : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= AGENT_LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign req_stall = full;
   assign accept    = req_valid && !full;

   bhp_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_data_byte),
      .end_of_packet (req_end_of_packet),
      .agent_limit   (limit_ff),
      .result        (step_result)
   );

   bhp_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (step_result),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_out_byte         = rsp_data.out_byte;
   assign rsp_role             = rsp_data.role;
   assign rsp_name_length      = rsp_data.name_length;
   assign rsp_origin_time_ms   = rsp_data.origin_time_ms;
   assign rsp_transmit_time_ms = rsp_data.transmit_time_ms;
   assign rsp_status           = rsp_data.status;
   assign rsp_last             = rsp_data.last;

endmodule

/* dv/belief_packet_header_parser_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// belief_packet_header_parser_tb
// Self-checking bench for the byte-wise belief packet header parser.
// ----------------------------------------------------------------------------
// A short table of hand-picked bytes covers compressed, early-ended and
// option-chain packets with roles and status typed in. Crafted and random
// packets then follow under several agent name limits: well-formed headers
// with random content, cut-short packets, compressed packets and raw noise.
// Every byte taken is run through a local header predictor, and each result
// is compared field by field with the oldest prediction. Both handshakes get
// random idle gaps and stalls.
// ----------------------------------------------------------------------------
module belief_packet_header_parser_tb;
   import bhp_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              eop;
      logic [ROLE_W-1:0] role;
      logic [STAT_W-1:0] status;
   } stim_row_type;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [BYTE_W-1:0]        req_data_byte = '0;
   logic                     req_end_of_packet = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [BYTE_W-1:0]        rsp_out_byte;
   logic [ROLE_W-1:0]        rsp_role;
   logic [LEN_W-1:0]         rsp_name_length;
   logic signed [TIME_W-1:0] rsp_origin_time_ms;
   logic signed [TIME_W-1:0] rsp_transmit_time_ms;
   logic [STAT_W-1:0]        rsp_status;
   logic                     rsp_last;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [LEN_W-1:0]         csr_data = '0;

   // header predictor state
   logic [PHASE_W-1:0] hdr_phase;
   logic [LEN_W-1:0]   hdr_left;
   logic               hdr_more_opts;
   logic [LEN_W-1:0]   hdr_name_len;
   logic [TIME_W-1:0]  hdr_ts;
   logic [TIME_W-1:0]  hdr_tx;
   logic [STAT_W-1:0]  hdr_state;
   logic [LEN_W-1:0]   hdr_agent_len;
   logic [LEN_W-1:0]   agent_limit = AGENT_LIMIT_RESET;

   result_type        parsed_due [$];
   result_type        head;
   logic [BYTE_W-1:0] pkt_bytes [$];
   int                mismatches = 0;
   int                sent_bytes = 0;
   bit                burst = 1'b0;

   stim_row_type directed_rows [11] = '{
      '{8'h04, 1'b0, ROLE_FLAGS,   ST_COMPRESSED},
      '{8'hFF, 1'b1, ROLE_SKIPPED, ST_COMPRESSED},
      '{8'h00, 1'b1, ROLE_FLAGS,   ST_TRUNCATED},
      '{8'h9C, 1'b0, ROLE_FLAGS,   ST_OK},
      '{8'h00, 1'b0, ROLE_SKIPPED, ST_OK},
      '{8'h80, 1'b0, ROLE_OPTION,  ST_OK},
      '{8'hFF, 1'b0, ROLE_OPTION,  ST_OK},
      '{8'h01, 1'b0, ROLE_OPTION,  ST_OK},
      '{8'hAA, 1'b0, ROLE_OPTION,  ST_OK},
      '{8'h55, 1'b0, ROLE_OPTION,  ST_OK},
      '{8'h12, 1'b1, ROLE_SKIPPED, ST_TRUNCATED}
   };

   belief_packet_header_parser dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_byte        (req_data_byte),
      .req_end_of_packet    (req_end_of_packet),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_role             (rsp_role),
      .rsp_name_length      (rsp_name_length),
      .rsp_origin_time_ms   (rsp_origin_time_ms),
      .rsp_transmit_time_ms (rsp_transmit_time_ms),
      .rsp_status           (rsp_status),
      .rsp_last             (rsp_last),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("belief_packet_header_parser_tb NOT OK");
      $finish;
   end

   function automatic void clear_header();
      hdr_phase     = PH_FLAGS;
      hdr_left      = '0;
      hdr_more_opts = 1'b0;
      hdr_name_len  = '0;
      hdr_ts        = '0;
      hdr_tx        = '0;
      hdr_state     = ST_OK;
      hdr_agent_len = '0;
   endfunction

   function automatic void leave_options();
      if (hdr_more_opts) begin
         hdr_phase = PH_OPTLEN;
      end else begin
         hdr_phase = PH_SKIP8;
         hdr_left  = LEN_W'(SKIP_COUNT);
      end
   endfunction

   function automatic result_type parse_byte(input logic [BYTE_W-1:0] b, input logic eop);
      result_type        r;
      logic [ROLE_W-1:0] role;
      logic [STAT_W-1:0] st;
      role = ROLE_SKIPPED;
      case (hdr_phase)
         PH_FLAGS: begin
            role = ROLE_FLAGS;
            if ((b & COMP_MASK) == COMP_VALUE) begin
               hdr_state = ST_COMPRESSED;
               hdr_phase = PH_IGNORE;
            end else begin
               hdr_more_opts = b[7];
               hdr_phase     = PH_SKIP1;
            end
         end
         PH_SKIP1: begin
            leave_options();
         end
         PH_OPTLEN: begin
            role          = ROLE_OPTION;
            hdr_more_opts = b[7];
            hdr_left      = LEN_W'(b & OPT_LEN_MASK) + 16'd1;
            hdr_phase     = PH_OPTBODY;
         end
         PH_OPTBODY: begin
            role     = ROLE_OPTION;
            hdr_left = hdr_left - 16'd1;
            if (hdr_left == 0) leave_options();
         end
         PH_SKIP8: begin
            hdr_left = hdr_left - 16'd1;
            if (hdr_left == 0) begin
               hdr_phase    = PH_NAMELEN;
               hdr_left     = LEN_W'(LEN_BYTES);
               hdr_name_len = '0;
            end
         end
         PH_NAMELEN: begin
            role         = ROLE_NAME_LEN;
            hdr_name_len = {hdr_name_len[7:0], b};
            hdr_left     = hdr_left - 16'd1;
            if (hdr_left == 0) begin
               if (hdr_name_len == 0) begin
                  hdr_phase = PH_TS;
                  hdr_left  = LEN_W'(TIME_BYTES);
               end else begin
                  hdr_phase = PH_NAME;
                  hdr_left  = hdr_name_len;
               end
            end
         end
         PH_NAME: begin
            role     = ROLE_NAME;
            hdr_left = hdr_left - 16'd1;
            if (hdr_left == 0) begin
               hdr_phase = PH_TS;
               hdr_left  = LEN_W'(TIME_BYTES);
            end
         end
         PH_TS: begin
            role     = ROLE_TIMESTAMP;
            hdr_ts   = {hdr_ts[TIME_W-9:0], b};
            hdr_left = hdr_left - 16'd1;
            if (hdr_left == 0) begin
               hdr_phase = PH_TX;
               hdr_left  = LEN_W'(TIME_BYTES);
            end
         end
         PH_TX: begin
            role     = ROLE_TRANSMIT;
            hdr_tx   = {hdr_tx[TIME_W-9:0], b};
            hdr_left = hdr_left - 16'd1;
            if (hdr_left == 0) begin
               hdr_phase     = PH_AGENTLEN;
               hdr_left      = LEN_W'(LEN_BYTES);
               hdr_agent_len = '0;
            end
         end
         PH_AGENTLEN: begin
            role          = ROLE_AGENT_LEN;
            hdr_agent_len = {hdr_agent_len[7:0], b};
            hdr_left      = hdr_left - 16'd1;
            if (hdr_left == 0) begin
               if (hdr_agent_len > agent_limit) begin
                  hdr_state = ST_DROPPED;
                  hdr_phase = PH_IGNORE;
               end else if (hdr_agent_len == 0) begin
                  hdr_phase = PH_PAYLOAD;
               end else begin
                  hdr_phase = PH_AGENT;
                  hdr_left  = hdr_agent_len;
               end
            end
         end
         PH_AGENT: begin
            role     = ROLE_AGENT;
            hdr_left = hdr_left - 16'd1;
            if (hdr_left == 0) hdr_phase = PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            role = ROLE_PAYLOAD;
         end
         default: begin
            role      = ROLE_SKIPPED;
            hdr_phase = PH_IGNORE;
         end
      endcase
      st = hdr_state;
      if (eop && st == ST_OK && hdr_phase != PH_PAYLOAD) st = ST_TRUNCATED;
      r.out_byte         = b;
      r.role             = role;
      r.name_length      = (hdr_phase == PH_NAMELEN) ? '0 : hdr_name_len;
      r.origin_time_ms   = hdr_ts;
      r.transmit_time_ms = hdr_tx;
      r.status           = st;
      r.last             = eop;
      if (eop) clear_header();
      return r;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   task automatic send_item(input logic [BYTE_W-1:0] b, input logic eop, input bit typed,
                            input logic [ROLE_W-1:0] role, input logic [STAT_W-1:0] status);
      int         gap;
      result_type r;
      gap = burst ? 0 : gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= b;
      req_end_of_packet <= eop;
      do @(posedge clock); while (req_stall);
      r = parse_byte(b, eop);
      if (typed) begin
         r.role   = role;
         r.status = status;
      end
      parsed_due.push_back(r);
      sent_bytes++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (parsed_due.size() != 0);
   endtask

   task automatic write_limit(input logic [LEN_W-1:0] value);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      agent_limit = value;
   endtask

   // Header with cut-off points: a long name or agent name stops the build early.
   task automatic build_packet(input logic [LEN_W-1:0] name_len,
                               input logic [LEN_W-1:0] agent_len,
                               input int n_opts, input int n_payload);
      logic [BYTE_W-1:0] flags;
      int                olen;
      pkt_bytes.delete();
      flags    = 8'($urandom);
      flags[7] = (n_opts > 0);
      if ((flags & COMP_MASK) == COMP_VALUE) flags[3] = 1'b1;
      pkt_bytes.push_back(flags);
      pkt_bytes.push_back(8'($urandom));
      for (int i = 0; i < n_opts; i++) begin
         olen = ($urandom_range(0, 19) == 0) ? 127 : $urandom_range(0, 4);
         pkt_bytes.push_back(8'(olen) | ((i < n_opts - 1) ? 8'h80 : 8'h00));
         repeat (olen + 1) pkt_bytes.push_back(8'($urandom));
      end
      repeat (SKIP_COUNT) pkt_bytes.push_back(8'($urandom));
      pkt_bytes.push_back(name_len[15:8]);
      pkt_bytes.push_back(name_len[7:0]);
      if (name_len > 40) begin
         repeat (40) pkt_bytes.push_back(8'($urandom));
         return;
      end
      repeat (name_len) pkt_bytes.push_back(8'($urandom));
      repeat (2 * TIME_BYTES) pkt_bytes.push_back(8'($urandom));
      pkt_bytes.push_back(agent_len[15:8]);
      pkt_bytes.push_back(agent_len[7:0]);
      if (agent_len > agent_limit) begin
         repeat ($urandom_range(0, 4)) pkt_bytes.push_back(8'($urandom));
         return;
      end
      if (agent_len > 40) begin
         repeat (40) pkt_bytes.push_back(8'($urandom));
         return;
      end
      repeat (agent_len) pkt_bytes.push_back(8'($urandom));
      repeat (n_payload) pkt_bytes.push_back(8'($urandom));
   endtask

   task automatic send_packet(input int last_idx);
      for (int i = 0; i <= last_idx; i++)
         send_item(pkt_bytes[i], i == last_idx, 1'b0, ROLE_FLAGS, ST_OK);
      if ($urandom_range(0, 7) == 0) wait_drained();
   endtask

   task automatic send_random_packet();
      int                kind;
      int                r;
      int                cut;
      logic [LEN_W-1:0]  nlen;
      logic [LEN_W-1:0]  alen;
      logic [BYTE_W-1:0] flags;
      kind  = $urandom_range(0, 99);
      burst = ($urandom_range(0, 4) == 0);
      if (kind < 75) begin
         r = $urandom_range(0, 99);
         if (r < 20) nlen = '0;
         else if (r < 80) nlen = LEN_W'($urandom_range(1, 6));
         else nlen = LEN_W'($urandom);
         r = $urandom_range(0, 99);
         if (r < 15) alen = '0;
         else if (r < 30) alen = (agent_limit <= 40) ? agent_limit : LEN_W'($urandom_range(1, 6));
         else if (r < 50) alen = (agent_limit == 16'hFFFF) ? 16'hFFFF : agent_limit + 16'd1;
         else if (r < 60) alen = LEN_W'($urandom);
         else alen = LEN_W'($urandom_range(1, 6));
         build_packet(nlen, alen, $urandom_range(0, 3), $urandom_range(0, 6));
         cut = (kind < 55) ? pkt_bytes.size() - 1 : $urandom_range(0, pkt_bytes.size() - 1);
      end else if (kind < 88) begin
         pkt_bytes.delete();
         flags      = 8'($urandom);
         flags[4:2] = 3'b001;
         pkt_bytes.push_back(flags);
         repeat ($urandom_range(0, 7)) pkt_bytes.push_back(8'($urandom));
         cut = pkt_bytes.size() - 1;
      end else begin
         pkt_bytes.delete();
         repeat ($urandom_range(1, 12)) pkt_bytes.push_back(8'($urandom));
         cut = pkt_bytes.size() - 1;
      end
      send_packet(cut);
   endtask

   initial begin : stall_gen
      int free_n;
      int hold_n;
      forever begin
         free_n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
         hold_n = gap_len();
         rsp_stall <= 1'b0;
         repeat (free_n) @(posedge clock);
         if (hold_n > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_n) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (parsed_due.size() == 0) begin
            $error("unexpected item: out_byte %0h role %0d", rsp_out_byte, rsp_role);
            mismatches++;
         end else begin
            head = parsed_due.pop_front();
            if (rsp_out_byte !== head.out_byte) begin
               $error("out_byte: expected %0h, got %0h", head.out_byte, rsp_out_byte);
               mismatches++;
            end
            if (rsp_role !== head.role) begin
               $error("role: expected %0d, got %0d", head.role, rsp_role);
               mismatches++;
            end
            if (rsp_name_length !== head.name_length) begin
               $error("name_length: expected %0d, got %0d", head.name_length, rsp_name_length);
               mismatches++;
            end
            if (rsp_origin_time_ms !== head.origin_time_ms) begin
               $error("origin_time_ms: expected %0h, got %0h", head.origin_time_ms,
                      rsp_origin_time_ms);
               mismatches++;
            end
            if (rsp_transmit_time_ms !== head.transmit_time_ms) begin
               $error("transmit_time_ms: expected %0h, got %0h", head.transmit_time_ms,
                      rsp_transmit_time_ms);
               mismatches++;
            end
            if (rsp_status !== head.status) begin
               $error("status: expected %0d, got %0d", head.status, rsp_status);
               mismatches++;
            end
            if (rsp_last !== head.last) begin
               $error("last: expected %0d, got %0d", head.last, rsp_last);
               mismatches++;
            end
         end
      end
   end

   initial begin : stimulus
      logic [LEN_W-1:0] limit_plan [4];
      int               phase_start;
      limit_plan = '{16'd3, 16'd0, 16'hFFFF, 16'd0};
      limit_plan[3] = LEN_W'($urandom_range(1, 300));
      clear_header();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].data, directed_rows[i].eop, 1'b1,
                   directed_rows[i].role, directed_rows[i].status);

      for (int ph = 0; ph < 5; ph++) begin
         if (ph > 0) write_limit(limit_plan[ph-1]);
         if (ph == 1) begin
            // zero name and agent lengths, agent at the limit, one past it,
            // and a packet ending on its last header byte
            build_packet(16'd0, 16'd0, 0, 2);
            send_packet(pkt_bytes.size() - 1);
            build_packet(16'd2, agent_limit, 1, 1);
            send_packet(pkt_bytes.size() - 1);
            build_packet(16'd1, agent_limit + 16'd1, 2, 2);
            send_packet(pkt_bytes.size() - 1);
            build_packet(16'd0, agent_limit, 0, 0);
            send_packet(pkt_bytes.size() - 1);
         end
         phase_start = sent_bytes;
         while (sent_bytes - phase_start < 175) send_random_packet();
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("belief_packet_header_parser_tb OK");
      end else begin
         $display("belief_packet_header_parser_tb NOT OK");
      end
      $finish;
   end

endmodule
